>>> rtl/fic_pkg.sv
package fic_pkg;

  localparam int MaxLenDefault = 32;
  localparam int ElemBits      = 8;
  localparam int CoefBits      = 21;
  localparam int IndexBits     = 6;
  localparam int ProdBits      = 2 * ElemBits;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/fft_integer_convolution.sv
// Operation: after the word with tlast, each coefficient k is built by multiply-accumulate
// on one shared 8x8 multiplier in ST_MAC, one tap per element of a, then ST_DRAIN adds
// the last product; the coefficient then waits in the output register (ST_EMIT) until
// taken.
// Throughput: load words are taken one per cycle; no word is taken while a
// product is computed or emitted.
// Reset: rst_ni clears the sequencer, the element counts and the drop flag.
module fft_integer_convolution #(
  parameter int MAX_LEN = fic_pkg::MaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: a_value[7:0], a_present[8], b_value[16:9], b_present[17], zero[23:18]
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // batch_end
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: coefficient[20:0], coeff_index[26:21], zero[31:27]
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // run_end
  output logic        m_axis_tuser_o,   // dropped
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);
  import fic_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  state_e state_q, state_d;

  // element stores, each read at one index per cycle
  logic [ElemBits-1:0] a_mem_q [MAX_LEN];
  logic [ElemBits-1:0] b_mem_q [MAX_LEN];
  logic [CntW-1:0]     a_cnt_q, b_cnt_q;
  logic                drop_q;

  logic [IndexBits-1:0] k_q;      // coefficient being built
  logic [IdxW-1:0]      i_q;      // index into a
  logic [ProdBits-1:0]  prod_q;   // registered product
  logic [CoefBits-1:0]  acc_q;
  logic                 empty_q;  // one zero result for an empty sequence

  logic [ElemBits-1:0]  a_val, b_val;
  logic                 a_pres, b_pres, s_fire, m_fire;
  logic [IndexBits:0]   diff, total, k_next;
  logic                 tap_ok, i_last;

  assign a_val  = s_axis_tdata_i[ElemBits-1:0];
  assign a_pres = s_axis_tdata_i[8];
  assign b_val  = s_axis_tdata_i[9 +: ElemBits];
  assign b_pres = s_axis_tdata_i[17];

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  // b index is k - i; tap counts only where it lands inside b
  assign diff   = {1'b0, k_q} - (IndexBits+1)'(i_q);
  assign tap_ok = ({1'b0, k_q} >= (IndexBits+1)'(i_q)) &&
                  (diff < (IndexBits+1)'(b_cnt_q));
  assign i_last = (CntW'(i_q) == a_cnt_q - CntW'(1));
  assign total  = (IndexBits+1)'(a_cnt_q) + (IndexBits+1)'(b_cnt_q) - (IndexBits+1)'(1);
  assign k_next = {1'b0, k_q} + (IndexBits+1)'(1);

  assign m_axis_tdata_o = {5'b0, k_q, acc_q};
  assign m_axis_tlast_o = empty_q || (k_next == total);
  assign m_axis_tuser_o = drop_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_fire && s_axis_tlast_i) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (empty_q)     state_d = ST_EMIT;
        else if (i_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (m_fire) state_d = m_axis_tlast_o ? ST_LOAD : ST_MAC;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // counts, drop flag and sequencer indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      empty_q <= 1'b0;
    end else begin
      if (s_fire) begin
        if (a_pres && a_cnt_q < CntW'(MAX_LEN)) a_cnt_q <= a_cnt_q + CntW'(1);
        if (b_pres && b_cnt_q < CntW'(MAX_LEN)) b_cnt_q <= b_cnt_q + CntW'(1);
        // flag any element that finds its sequence full
        if ((a_pres && a_cnt_q >= CntW'(MAX_LEN)) ||
            (b_pres && b_cnt_q >= CntW'(MAX_LEN))) drop_q <= 1'b1;
        if (s_axis_tlast_i) begin
          k_q     <= '0;
          i_q     <= '0;
          // counts after this word's own elements
          empty_q <= ((a_cnt_q == '0) && !a_pres) || ((b_cnt_q == '0) && !b_pres);
        end
      end
      if (state_q == ST_MAC && !i_last && !empty_q) i_q <= i_q + IdxW'(1);
      if (m_fire) begin
        i_q <= '0;
        k_q <= k_next[IndexBits-1:0];
        if (m_axis_tlast_o) begin
          a_cnt_q <= '0;
          b_cnt_q <= '0;
          drop_q  <= 1'b0;
          empty_q <= 1'b0;
        end
      end
    end
  end

  // element stores and the shared multiply-accumulate unit
  always_ff @(posedge clk_i) begin
    if (s_fire && a_pres && a_cnt_q < CntW'(MAX_LEN)) a_mem_q[a_cnt_q[IdxW-1:0]] <= a_val;
    if (s_fire && b_pres && b_cnt_q < CntW'(MAX_LEN)) b_mem_q[b_cnt_q[IdxW-1:0]] <= b_val;
    unique case (state_q)
      ST_MAC: begin
        prod_q <= (tap_ok && !empty_q) ?
                  ProdBits'(a_mem_q[i_q] * b_mem_q[diff[IdxW-1:0]]) : '0;
        acc_q  <= acc_q + CoefBits'(prod_q);
      end
      ST_DRAIN: begin
        acc_q  <= acc_q + CoefBits'(prod_q);
        prod_q <= '0;
      end
      ST_EMIT: begin
        if (m_fire) acc_q <= '0;
      end
      default: begin
        // hold a clean accumulator for the first coefficient
        acc_q  <= '0;
        prod_q <= '0;
      end
    endcase
  end

  // never take and give words in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("load and emit overlap");

  // an empty batch gives exactly one word, marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && empty_q) |-> (m_axis_tlast_o && m_axis_tdata_o[20:0] == '0))
    else $error("empty batch result wrong");

  // the last word returns the block to loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast_o) |=> (s_axis_tready_o && a_cnt_q == '0 && b_cnt_q == '0))
    else $error("state not cleared after run");

endmodule

>>> verif/tb_fft_integer_convolution.sv
`timescale 1ns / 100ps

module tb_fft_integer_convolution;
  import fic_pkg::*;

  localparam int MaxLen   = MaxLenDefault;
  localparam int IdleLim  = 20000;

  typedef struct packed {
    logic [7:0] a_val;
    logic       a_pres;
    logic [7:0] b_val;
    logic       b_pres;
    logic       last;
  } load_word_t;

  typedef struct packed {
    logic [CoefBits-1:0]  coef;
    logic [IndexBits-1:0] idx;
    logic                 last;
    logic                 drop;
  } coef_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  fft_integer_convolution u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  load_word_t pending_words[$];
  coef_word_t expected_coefs[$];
  bit         stim_done = 1'b0;
  int         fail_cnt = 0;
  int         idle_cycles = 0;

  // Shadow copy of the two sequences held by the block.
  logic [7:0] seq_a[MaxLen];
  logic [7:0] seq_b[MaxLen];
  int         len_a = 0;
  int         len_b = 0;
  bit         overflow = 1'b0;

  // Append a word to the stimulus or the expected queue.
  task automatic queue_word(load_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic queue_coef(coef_word_t c);
    expected_coefs = {expected_coefs, c};
  endtask

  // Load one word into the shadow and, on tlast, queue the full product.
  task automatic convolve_word(load_word_t w);
    logic [31:0] sum;
    int total;
    coef_word_t c;
    if (w.a_pres) begin
      if (len_a < MaxLen) seq_a[len_a++] = w.a_val;
      else overflow = 1'b1;
    end
    if (w.b_pres) begin
      if (len_b < MaxLen) seq_b[len_b++] = w.b_val;
      else overflow = 1'b1;
    end
    if (w.last) begin
      if (len_a == 0 || len_b == 0) begin
        c = '{coef: '0, idx: '0, last: 1'b1, drop: overflow};
        queue_coef(c);
      end else begin
        total = len_a + len_b - 1;
        for (int k = 0; k < total; k++) begin
          sum = 0;
          for (int i = 0; i < len_a; i++)
            if (i <= k && k - i < len_b) sum += seq_a[i] * seq_b[k - i];
          c.coef = sum[CoefBits-1:0];
          c.idx  = k[IndexBits-1:0];
          c.last = (k + 1 == total);
          c.drop = overflow;
          queue_coef(c);
        end
      end
      len_a = 0;
      len_b = 0;
      overflow = 1'b0;
    end
  endtask

  function automatic load_word_t make_word(int a, bit ap, int b, bit bp, bit last);
    load_word_t w;
    w.a_val = a[7:0];
    w.a_pres = ap;
    w.b_val = b[7:0];
    w.b_pres = bp;
    w.last = last;
    return w;
  endfunction

  // Queue a batch of na and nb elements; values either random or all at max.
  task automatic add_batch(int na, int nb, bit max_vals);
    int steps;
    int a;
    int b;
    steps = (na > nb) ? na : nb;
    if (steps == 0) steps = 1;
    for (int i = 0; i < steps; i++) begin
      a = max_vals ? 255 : $urandom_range(255);
      b = max_vals ? 255 : $urandom_range(255);
      queue_word(make_word(a, i < na, b, i < nb, i == steps - 1));
    end
  endtask

  initial begin
    int na;
    int nb;
    // Directed: tiny products, empty sides, full-scale and overflowing batches.
    add_batch(1, 1, 1'b1);
    add_batch(0, 0, 1'b0);
    add_batch(3, 0, 1'b0);
    add_batch(0, 2, 1'b0);
    add_batch(2, 3, 1'b0);
    add_batch(MaxLen, MaxLen, 1'b1);
    add_batch(MaxLen + 2, 1, 1'b0);
    queue_word(make_word(0, 1'b1, 0, 1'b1, 1'b1));
    // Random: mostly short batches, sometimes full or overflowing.
    while (pending_words.size() < 460) begin
      case ($urandom_range(9))
        0: begin
          na = $urandom_range(MaxLen + 3);
          nb = $urandom_range(MaxLen + 3);
        end
        1: begin
          na = $urandom_range(2);
          nb = $urandom_range(2);
        end
        default: begin
          na = $urandom_range(1, 8);
          nb = $urandom_range(1, 8);
        end
      endcase
      if ($urandom_range(7) == 0) begin
        // gappy batch: present flags set at random, drop-free
        for (int i = 0; i < 6; i++)
          queue_word(make_word($urandom_range(255), 1'($urandom_range(1)),
                               $urandom_range(255), 1'($urandom_range(1)),
                               i == 5));
      end else begin
        add_batch(na, nb, 1'b0);
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: send in bursts, hold words until taken.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        convolve_word(pending_words.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b0, pending_words[0].b_pres, pending_words[0].b_val,
                       pending_words[0].a_pres, pending_words[0].a_val};
          s_tlast  <= pending_words[0].last;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random receiver stall pattern, compare each taken word.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    coef_word_t exp_w;
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      m_tready <= (stall_phase[7:6] == 2'b01) ? 1'b1 : ($urandom_range(3) != 0);
      if (m_tvalid && m_tready) begin
        if (expected_coefs.size() == 0) begin
          $error("unexpected coefficient word %h", m_tdata);
          fail_cnt++;
        end else begin
          exp_w = expected_coefs.pop_front();
          if (m_tdata[20:0] !== exp_w.coef) begin
            $error("coefficient exp %0d got %0d", exp_w.coef, m_tdata[20:0]);
            fail_cnt++;
          end
          if (m_tdata[26:21] !== exp_w.idx) begin
            $error("coeff_index exp %0d got %0d", exp_w.idx, m_tdata[26:21]);
            fail_cnt++;
          end
          if (m_tlast !== exp_w.last) begin
            $error("run_end exp %0b got %0b", exp_w.last, m_tlast);
            fail_cnt++;
          end
          if (m_tuser !== exp_w.drop) begin
            $error("dropped exp %0b got %0b", exp_w.drop, m_tuser);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLim) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (stim_done && pending_words.size() == 0 && !s_tvalid && expected_coefs.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && expected_coefs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fic_pkg.sv
rtl/fft_integer_convolution.sv
verif/tb_fft_integer_convolution.sv
